// File: rtl/pba_pkg.sv
// Shared types, constants and helper functions of the paged block allocator.
`default_nettype none
package pba_pkg;

    localparam int NUM_PAGES      = 64;
    localparam int MAX_PAGE_BYTES = 256;

    localparam int PAGE_W        = $clog2(NUM_PAGES);
    localparam int PAGE_LOG2_MAX = $clog2(MAX_PAGE_BYTES);
    localparam int PAGE_LOG2_MIN = 3;
    localparam int MAP_W         = MAX_PAGE_BYTES / 4;
    localparam int BIT_W         = $clog2(MAP_W);
    localparam int MAX_CLASS     = PAGE_LOG2_MAX - 3;
    localparam int RUN_LIMIT     = 127;

    localparam int CFG_W    = 4;
    localparam int PL_W     = 4;
    localparam int OFF_W    = PAGE_LOG2_MAX;
    localparam int CLASS_W  = 3;
    localparam int RUN_W    = 7;
    localparam int SIZE_W   = 15;
    localparam int ADDR_W   = 14;
    localparam int STATUS_W = 2;
    localparam int NEED_W   = SIZE_W + 2;
    localparam int SUM_W    = ((PAGE_W > RUN_W) ? PAGE_W : RUN_W) + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    localparam logic [1:0] MODE_FREE  = 2'd0;
    localparam logic [1:0] MODE_SPLIT = 2'd2;
    localparam logic [1:0] MODE_RUN   = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd3;

    typedef struct packed {
        logic [0:0]        operation;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted_address;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic [CLASS_W-1:0] cls;
        logic [MAP_W-1:0]   map;
        logic [RUN_W-1:0]   run;
    } t_page_entry;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic rd;
        logic upd;
        logic sweep;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic early;
        logic is_free;
        logic scan_last;
        logic dec_sweep;
        logic dec_read;
        logic dec_fresh;
        logic upd_sweep;
        logic sweep_last;
        logic out_free;
    } t_dp_stat;

    // Mask of the blocks that exist in a page of 2^pl bytes split into class cls.
    function automatic logic [MAP_W-1:0] block_mask(input logic [PL_W-1:0] pl,
                                                    input logic [CLASS_W-1:0] cls);
        logic [PL_W:0]  bl;
        logic [PL_W:0]  sh;
        logic [BIT_W:0] n;
        logic [MAP_W:0] wide;
        bl   = (PL_W+1)'(cls) + (PL_W+1)'(2);
        sh   = (bl > {1'b0, pl}) ? '0 : ({1'b0, pl} - bl);
        n    = (BIT_W+1)'(1) << sh;
        wide = ((MAP_W+1)'(1) << n) - (MAP_W+1)'(1);
        return wide[MAP_W-1:0];
    endfunction

    function automatic logic [BIT_W-1:0] lowest_set(input logic [MAP_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// File: rtl/pba_ctrl.sv
// Sequencer of the paged block allocator: walks each item through its steps.
`default_nettype none
module pba_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  pba_pkg::t_dp_stat      i_stat,
    output pba_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_READ,
        S_UPDATE,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.early) begin
                    n_state = S_DONE;
                end else if (i_stat.is_free) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_stat.dec_sweep)      n_state = S_SWEEP;
                else if (i_stat.dec_read)  n_state = S_READ;
                else if (i_stat.dec_fresh) n_state = S_UPDATE;
                else                       n_state = S_DONE;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = i_stat.upd_sweep ? S_SWEEP : S_DONE;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/pba_datapath.sv
// Datapath of the paged block allocator: page table memory, scan and update logic.
`default_nettype none
module pba_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  pba_pkg::t_in_item                  i_in_item,
    input  wire logic                          i_cfg_valid,
    input  wire logic [pba_pkg::CFG_W-1:0]     i_cfg_data,
    input  pba_pkg::t_dp_cmd                   i_cmd,
    output pba_pkg::t_dp_stat                  o_stat,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output pba_pkg::t_out_item                 o_out_item
);

    localparam int PAGE_W  = pba_pkg::PAGE_W;
    localparam int PL_W    = pba_pkg::PL_W;
    localparam int OFF_W   = pba_pkg::OFF_W;
    localparam int MAP_W   = pba_pkg::MAP_W;
    localparam int BIT_W   = pba_pkg::BIT_W;
    localparam int RUN_W   = pba_pkg::RUN_W;
    localparam int CLASS_W = pba_pkg::CLASS_W;
    localparam int SIZE_W  = pba_pkg::SIZE_W;
    localparam int ADDR_W  = pba_pkg::ADDR_W;
    localparam int NEED_W  = pba_pkg::NEED_W;
    localparam int SUM_W   = pba_pkg::SUM_W;
    localparam int NP      = pba_pkg::NUM_PAGES;

    // ---------------- config ----------------
    logic [pba_pkg::CFG_W-1:0] r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pba_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // ---------------- item decode at accept ----------------
    logic [PL_W-1:0]          ld_pl;
    logic [SIZE_W:0]          ld_size;
    logic [SIZE_W:0]          ld_half;
    logic [SIZE_W:0]          ld_pbytes;
    logic [NEED_W-1:0]        ld_need;
    logic                     ld_large;
    logic                     ld_zero;
    logic                     ld_too_long;
    logic [CLASS_W-1:0]       ld_cls;
    logic [ADDR_W-1:0]        ld_page;
    logic                     ld_oob;
    logic [ADDR_W-1:0]        ld_off;
    logic [pba_pkg::STATUS_W-1:0] ld_status;

    always_comb begin
        if (r_cfg < PL_W'(pba_pkg::PAGE_LOG2_MIN))      ld_pl = PL_W'(pba_pkg::PAGE_LOG2_MIN);
        else if (r_cfg > PL_W'(pba_pkg::PAGE_LOG2_MAX)) ld_pl = PL_W'(pba_pkg::PAGE_LOG2_MAX);
        else                                            ld_pl = r_cfg;
        ld_size   = ({1'b0, i_in_item.request_size} + (SIZE_W+1)'(3)) & ~(SIZE_W+1)'(3);
        ld_pbytes = (SIZE_W+1)'(1) << ld_pl;
        ld_half   = (SIZE_W+1)'(1) << (ld_pl - PL_W'(1));
        ld_zero   = (ld_size == '0);
        ld_large  = (ld_size > ld_half);
        ld_need   = ({1'b0, ld_size} + {1'b0, ld_pbytes} - NEED_W'(1)) >> ld_pl;
        ld_too_long = (ld_need > NEED_W'(NP)) || (ld_need > NEED_W'(pba_pkg::RUN_LIMIT));
        ld_cls    = '0;
        for (int c = pba_pkg::MAX_CLASS; c >= 0; c--) begin
            if (((SIZE_W+1)'(4) << c) >= ld_size) ld_cls = CLASS_W'(c);
        end
        ld_page = i_in_item.address >> ld_pl;
        ld_oob  = (ld_page >= ADDR_W'(NP));
        ld_off  = i_in_item.address & ((ADDR_W'(1) << ld_pl) - ADDR_W'(1));
        if (i_in_item.operation == pba_pkg::OP_FREE) begin
            ld_status = ld_oob ? pba_pkg::ST_BAD_ADDR : pba_pkg::ST_OK;
        end else if (ld_zero) begin
            ld_status = pba_pkg::ST_ZERO_SIZE;
        end else if (ld_large && ld_too_long) begin
            ld_status = pba_pkg::ST_NO_SPACE;
        end else begin
            ld_status = pba_pkg::ST_OK;
        end
    end

    logic                 r_op;
    logic [PL_W-1:0]      r_pl;
    logic [CLASS_W-1:0]   r_cls;
    logic [RUN_W-1:0]     r_need;
    logic                 r_large;
    logic                 r_early;
    logic [PAGE_W-1:0]    r_page;
    logic [OFF_W-1:0]     r_off;

    // ---------------- page table ----------------
    pba_pkg::t_page_entry r_mem [NP];
    logic [NP-1:0]        r_vld;
    pba_pkg::t_page_entry r_rd_data;
    logic                 r_rd_vb;
    pba_pkg::t_page_entry rd_entry;

    logic                 rd_en;
    logic [PAGE_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [PAGE_W-1:0]    wr_addr;
    pba_pkg::t_page_entry wr_data;

    logic [PAGE_W-1:0]    r_scan_addr;
    logic [PAGE_W-1:0]    r_target;
    logic                 r_fresh;

    assign rd_en    = i_cmd.scan_step | i_cmd.rd;
    assign rd_addr  = i_cmd.scan_step ? r_scan_addr : r_target;
    assign rd_entry = r_rd_vb ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vb   <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // ---------------- scan evaluation ----------------
    logic              r_ev_valid;
    logic [PAGE_W-1:0] r_ev_idx;
    logic [RUN_W-1:0]  r_cnt;
    logic              r_found;
    logic [PAGE_W-1:0] r_run_start;
    logic [PAGE_W-1:0] r_run_end;
    logic              r_ex_found;
    logic [PAGE_W-1:0] r_ex_page;
    logic              r_fr_found;
    logic [PAGE_W-1:0] r_fr_page;
    logic              r_bs_found;
    logic [PAGE_W-1:0] r_bs_page;
    logic [CLASS_W-1:0] r_bs_cls;

    logic              ev_hasfree;
    logic [RUN_W-1:0]  ev_cnt_inc;
    logic [SUM_W-1:0]  ev_start;

    assign ev_hasfree = |(~rd_entry.map & pba_pkg::block_mask(r_pl, rd_entry.cls));
    assign ev_cnt_inc = r_cnt + RUN_W'(1);
    assign ev_start   = SUM_W'(r_ev_idx) + SUM_W'(1) - SUM_W'(r_need);

    // ---------------- update step ----------------
    logic [PL_W-1:0]   up_bl;
    logic [OFF_W-1:0]  up_low;
    logic [BIT_W-1:0]  up_fb;
    logic [MAP_W-1:0]  up_newmap;
    logic              up_free_ok;
    logic              up_run_ok;
    logic [SUM_W-1:0]  up_run_last;
    logic [BIT_W-1:0]  tk_b;
    logic [ADDR_W-1:0] tk_addr;
    logic [ADDR_W-1:0] tgt_base;

    always_comb begin
        up_bl = PL_W'(rd_entry.cls) + PL_W'(2);
        if (up_bl > r_pl) up_bl = r_pl;
        up_low      = r_off & ((OFF_W'(1) << up_bl) - OFF_W'(1));
        up_fb       = BIT_W'(r_off >> up_bl);
        up_newmap   = rd_entry.map & ~(MAP_W'(1) << up_fb);
        up_free_ok  = (rd_entry.mode == pba_pkg::MODE_SPLIT) && (up_low == '0)
                      && rd_entry.map[up_fb];
        up_run_ok   = (rd_entry.mode == pba_pkg::MODE_RUN) && (r_off == '0)
                      && (rd_entry.run != '0);
        up_run_last = SUM_W'(r_page) + SUM_W'(rd_entry.run) - SUM_W'(1);
        if (up_run_last > SUM_W'(NP - 1)) up_run_last = SUM_W'(NP - 1);
        tk_b     = pba_pkg::lowest_set(~rd_entry.map & pba_pkg::block_mask(r_pl, rd_entry.cls));
        tgt_base = ADDR_W'(r_target) << r_pl;
        tk_addr  = tgt_base + (ADDR_W'(tk_b) << (PL_W'(rd_entry.cls) + PL_W'(2)));
    end

    // ---------------- sweep over a page run ----------------
    logic [PAGE_W-1:0] r_sw_ptr;
    logic [PAGE_W-1:0] r_sw_last;
    logic              r_sw_free;

    // write port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_target;
        wr_data = '0;
        if (i_cmd.sweep) begin
            wr_en   = 1'b1;
            wr_addr = r_sw_ptr;
            if (!r_sw_free) begin
                wr_data.mode = pba_pkg::MODE_RUN;
                wr_data.run  = (r_sw_ptr == r_run_start) ? r_need : '0;
            end
        end else if (i_cmd.upd) begin
            if (r_op == pba_pkg::OP_FREE) begin
                if (up_free_ok) begin
                    wr_en = 1'b1;
                    if (up_newmap != '0) begin
                        wr_data     = rd_entry;
                        wr_data.map = up_newmap;
                    end
                end
            end else if (r_fresh) begin
                wr_en        = 1'b1;
                wr_data.mode = pba_pkg::MODE_SPLIT;
                wr_data.cls  = r_cls;
                wr_data.map  = MAP_W'(1);
            end else begin
                wr_en       = 1'b1;
                wr_data     = rd_entry;
                wr_data.map = rd_entry.map | (MAP_W'(1) << tk_b);
            end
        end
    end

    // ---------------- result and output register ----------------
    pba_pkg::t_out_item r_res;
    logic               r_out_valid;
    pba_pkg::t_out_item r_out_item;
    logic               out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_item.operation;
            r_pl     <= ld_pl;
            r_cls    <= ld_cls;
            r_need   <= RUN_W'(ld_need);
            r_large  <= ld_large;
            r_early  <= (ld_status != pba_pkg::ST_OK);
            r_page   <= PAGE_W'(ld_page);
            r_off    <= OFF_W'(ld_off);
            r_target <= PAGE_W'(ld_page);
            r_res    <= '{granted_address: '0, status: ld_status};
        end
        if (i_cmd.scan_start) begin
            r_cnt <= '0;
        end else if (r_ev_valid) begin
            r_cnt <= (rd_entry.mode == pba_pkg::MODE_FREE) ? ev_cnt_inc : '0;
        end
        if (r_ev_valid && !r_found && rd_entry.mode == pba_pkg::MODE_FREE
            && ev_cnt_inc == r_need) begin
            r_run_start <= PAGE_W'(ev_start);
            r_run_end   <= r_ev_idx;
        end
        if (r_ev_valid && rd_entry.mode == pba_pkg::MODE_SPLIT && ev_hasfree) begin
            if (rd_entry.cls == r_cls && !r_ex_found) r_ex_page <= r_ev_idx;
            if (rd_entry.cls >= r_cls && (!r_bs_found || rd_entry.cls < r_bs_cls)) begin
                r_bs_page <= r_ev_idx;
                r_bs_cls  <= rd_entry.cls;
            end
        end
        if (r_ev_valid && rd_entry.mode == pba_pkg::MODE_FREE && !r_fr_found) begin
            r_fr_page <= r_ev_idx;
        end
        r_ev_idx <= r_scan_addr;
        if (i_cmd.decide) begin
            if (r_large) begin
                if (r_found) begin
                    r_sw_ptr  <= r_run_start;
                    r_sw_last <= r_run_end;
                    r_sw_free <= 1'b0;
                    r_res     <= '{granted_address: ADDR_W'(r_run_start) << r_pl,
                                   status: pba_pkg::ST_OK};
                end else begin
                    r_res <= '{granted_address: '0, status: pba_pkg::ST_NO_SPACE};
                end
            end else if (r_ex_found) begin
                r_target <= r_ex_page;
                r_fresh  <= 1'b0;
            end else if (r_fr_found) begin
                r_target <= r_fr_page;
                r_fresh  <= 1'b1;
            end else if (r_bs_found) begin
                r_target <= r_bs_page;
                r_fresh  <= 1'b0;
            end else begin
                r_res <= '{granted_address: '0, status: pba_pkg::ST_NO_SPACE};
            end
        end
        if (i_cmd.upd) begin
            if (r_op == pba_pkg::OP_FREE) begin
                r_sw_ptr  <= r_page;
                r_sw_last <= PAGE_W'(up_run_last);
                r_sw_free <= 1'b1;
                r_res <= '{granted_address: '0,
                           status: (up_run_ok || up_free_ok) ? pba_pkg::ST_OK
                                                             : pba_pkg::ST_BAD_ADDR};
            end else if (r_fresh) begin
                r_res <= '{granted_address: tgt_base, status: pba_pkg::ST_OK};
            end else begin
                r_res <= '{granted_address: tk_addr, status: pba_pkg::ST_OK};
            end
        end
        if (i_cmd.sweep) r_sw_ptr <= r_sw_ptr + PAGE_W'(1);
        if (i_cmd.out_load) r_out_item <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_ev_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_ex_found  <= 1'b0;
            r_fr_found  <= 1'b0;
            r_bs_found  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ev_valid <= i_cmd.scan_step;
            if (i_cmd.scan_start) begin
                r_scan_addr <= '0;
                r_found     <= 1'b0;
                r_ex_found  <= 1'b0;
                r_fr_found  <= 1'b0;
                r_bs_found  <= 1'b0;
            end else begin
                if (i_cmd.scan_step) r_scan_addr <= r_scan_addr + PAGE_W'(1);
                if (r_ev_valid && rd_entry.mode == pba_pkg::MODE_FREE
                    && ev_cnt_inc == r_need) begin
                    r_found <= 1'b1;
                end
                if (r_ev_valid && rd_entry.mode == pba_pkg::MODE_SPLIT && ev_hasfree) begin
                    if (rd_entry.cls == r_cls) r_ex_found <= 1'b1;
                    if (rd_entry.cls >= r_cls) r_bs_found <= 1'b1;
                end
                if (r_ev_valid && rd_entry.mode == pba_pkg::MODE_FREE) r_fr_found <= 1'b1;
            end
            if (i_cmd.out_load)  r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // ---------------- status to sequencer ----------------
    always_comb begin
        o_stat            = '0;
        o_stat.early      = r_early;
        o_stat.is_free    = (r_op == pba_pkg::OP_FREE);
        o_stat.scan_last  = (r_scan_addr == PAGE_W'(NP - 1));
        o_stat.dec_sweep  = r_large && r_found;
        o_stat.dec_read   = !r_large && (r_ex_found || (!r_fr_found && r_bs_found));
        o_stat.dec_fresh  = !r_large && !r_ex_found && r_fr_found;
        o_stat.upd_sweep  = (r_op == pba_pkg::OP_FREE) && up_run_ok;
        o_stat.sweep_last = (r_sw_ptr == r_sw_last);
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

// File: rtl/paged_block_allocator_top.sv
// Top level of the paged block allocator: sequencer plus datapath.
//
// Paged power-of-two block allocator over an arena of 64 pages of 2^page_size_log2
// bytes (effective value clamped to 3..8). Each item is an allocate or a free and
// gives exactly one result item. One item is processed at a time; the input stalls
// from acceptance until the result has been moved into the output register, while
// a result already sitting there may still wait for the consumer. A free reads and
// updates its page and, for a run, then releases each of its pages in turn; an
// allocate that is not rejected up front walks the page table through its single
// read port, one page per cycle, then reads and updates a split page, writes a
// fresh page without a read, or claims a run page by page. Zero sizes, runs too
// long for the arena and free addresses out of range answer without a scan. The
// page table is cleared at reset through per-page valid bits, so no clearing pass
// is needed. The configuration register is always ready and must only be written
// while no item is in flight.
`default_nettype none
module paged_block_allocator_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // request items
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  pba_pkg::t_in_item               i_in_item,
    // result items
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output pba_pkg::t_out_item              o_out_item,
    // page size register write
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [pba_pkg::CFG_W-1:0]  i_cfg_data
);

    pba_pkg::t_dp_cmd  cmd;
    pba_pkg::t_dp_stat stat;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    pba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pba_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// File: rtl/pba_checker.sv
// Port-level checks of the paged block allocator and their bind.
`default_nettype none
module pba_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input pba_pkg::t_out_item      o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != pba_pkg::ST_OK)
        |-> (o_out_item.granted_address == '0))
        else $error("failed result carries an address");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while one is in work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind paged_block_allocator_top pba_checker u_pba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
